[rtl/msr_pkg.sv]
package msr_pkg;

  localparam int W = 32;                     // operand and modulus width
  localparam int CW = $clog2(W + 1);         // bit counter of the multiplier
  localparam int AW = $clog2(W);             // exponent of two in p-1, bit index
  localparam int NW = 13;                    // non-residue candidate, top bit = limit hit
  localparam logic [W-1:0] P_RESET = W'(3);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONRES = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FINISH,
    OP_POW_EULER,
    OP_SPLIT_STEP,
    OP_N_INIT,
    OP_JAC_INIT,
    OP_JAC_HALF,
    OP_JAC_SWAP,
    OP_JAC_REM,
    OP_N_INC,
    OP_POW_R,
    OP_POW_Y,
    OP_POW_B,
    OP_J_INIT,
    OP_POW_BJ2,
    OP_POW_BJ,
    OP_MUL_ACC,
    OP_MUL_BASE,
    OP_MUL_TY,
    OP_MUL_TT,
    OP_J_UPD,
    OP_MUL_ROOT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic a_ge_p;
    logic a_zero;
    logic p_bad;
    logic pe_zero;
    logic pe_odd;
    logic pa_one;
    logic s_even;
    logic ja_zero;
    logic ja_even;
    logic jac_neg;
    logic n_ok;
    logic k_more;
    logic sq_zero;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/modular_square_root.sv]
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/tready         tdata[31:0] value
// m_axis    out  m_axis_tvalid/tready         tdata[31:0] root, [33:32] status, [39:34] 0
// cfg       in   cfg_we_i (no back-pressure)  cfg_wdata_i = prime modulus p
//
// One transaction at a time. Every modular product runs on one bit-serial
// multiplier: it is issued, makes one shift-add step per operand bit, then
// signals done. Out-of-range, zero and bad-modulus inputs are settled in
// S_CHECK and their result is loaded from S_DONE once the output slot is
// free, after which S_IDLE takes the next input; a full Tonelli-Shanks run
// takes longer the more products it needs, most for p-1 with many factors of two.
// Reset: async active low, p returns to 3, no result pending.
// A finished result waits in the output register; a new input is taken
// while it waits, the next result is held back until it is taken.
module modular_square_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] root, [33:32] status, [39:34] zero
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i     // prime modulus
);
  import msr_pkg::*;

  cmd_t         cmd;
  sts_t         sts;
  logic [W-1:0] root;
  logic [1:0]   status;

  msr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  msr_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_value_i   (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_root_o   (root),
    .out_status_o (status)
  );

  assign m_axis_tdata = {6'd0, status, root};

  // status code 3 is never produced
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("illegal status");

  // a failed request always reports root zero
  a_fail_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] != ST_OK |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero root on failure");

  // the multiplier never finishes while the block is idle
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.mul_done |-> !s_axis_tready)
    else $error("multiplier done while idle");

  // a result is only loaded when the output slot is free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_OUT |-> sts.out_free)
    else $error("result overwritten");

endmodule

[rtl/msr_mulmod.sv]
module msr_mulmod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [msr_pkg::W-1:0] x_i,   // must be below m_i (or 1)
  input  logic [msr_pkg::W-1:0] e_i,   // scanned MSB first
  input  logic [msr_pkg::W-1:0] m_i,
  output logic                 done_o,
  output logic [msr_pkg::W-1:0] res_o
);
  import msr_pkg::*;

  logic [W-1:0]  acc_q, acc_d, x_q, e_q, m_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    dbl, red1, sum, red2;

  // acc = 2*acc + bit*x mod m, one conditional subtract after the doubling and one after the add
  always_comb begin
    dbl   = {acc_q, 1'b0};
    red1  = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum   = red1 + (e_q[W-1] ? {1'b0, x_q} : '0);
    red2  = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    acc_d = red2[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      e_q   <= e_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      e_q   <= {e_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

[rtl/msr_datapath.sv]
module msr_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msr_pkg::cmd_t         cmd_i,
  output msr_pkg::sts_t         sts_o,
  input  logic [msr_pkg::W-1:0] in_value_i,
  input  logic                  cfg_we_i,
  input  logic [msr_pkg::W-1:0] cfg_wdata_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [msr_pkg::W-1:0] out_root_o,
  output logic [1:0]            out_status_o
);
  import msr_pkg::*;

  logic [W-1:0]  p_q, a_q, s_q, r_q, y_q, b_q, j_q, t_q;
  logic [W-1:0]  pa_q, pb_q, pe_q, ja_q, jm_q, root_q, out_root_q;
  logic [AW-1:0] alpha_q, k_q, sq_q;
  logic [NW-1:0] n_q;
  logic          neg_q, res_valid_q;
  logic [1:0]    status_q, out_status_q;
  op_e           dest_q;

  logic          mul_start, mul_done;
  logic [W-1:0]  mx, me, mm, mres;
  logic          out_load;

  msr_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mx),
    .e_i     (me),
    .m_i     (mm),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  always_comb begin
    mul_start = 1'b1;
    mx = pa_q;
    me = pb_q;
    mm = p_q;
    unique case (cmd_i.op)
      OP_MUL_ACC:  begin mx = pa_q; me = pb_q; end
      OP_MUL_BASE: begin mx = pb_q; me = pb_q; end
      OP_JAC_REM:  begin mx = W'(1); me = ja_q; mm = jm_q; end
      OP_MUL_TY:   begin mx = y_q;  me = pa_q; end
      OP_MUL_TT:   begin mx = t_q;  me = t_q;  end
      OP_MUL_ROOT: begin mx = r_q;  me = pa_q; end
      default:     mul_start = 1'b0;
    endcase
  end

  assign out_load = (cmd_i.op == OP_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= P_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        p_q <= cfg_wdata_i;
      end
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      dest_q <= cmd_i.op;
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        a_q     <= in_value_i;
        s_q     <= p_q - W'(1);
        alpha_q <= '0;
      end
      OP_FINISH: begin
        root_q   <= '0;
        status_q <= cmd_i.res_status;
      end
      OP_POW_EULER: begin
        pa_q <= W'(1); pb_q <= a_q; pe_q <= (p_q - W'(1)) >> 1;
      end
      OP_SPLIT_STEP: begin
        s_q     <= s_q >> 1;
        alpha_q <= alpha_q + AW'(1);
      end
      OP_N_INIT: n_q <= NW'(2);
      OP_JAC_INIT: begin
        ja_q  <= W'(n_q);
        jm_q  <= p_q;
        neg_q <= 1'b0;
      end
      OP_JAC_HALF: begin
        ja_q <= ja_q >> 1;
        if (jm_q[2:0] == 3'd3 || jm_q[2:0] == 3'd5) begin
          neg_q <= ~neg_q;
        end
      end
      OP_JAC_SWAP: begin
        ja_q <= jm_q;
        jm_q <= ja_q;
        if (ja_q[1:0] == 2'd3 && jm_q[1:0] == 2'd3) begin
          neg_q <= ~neg_q;
        end
      end
      OP_N_INC: n_q <= n_q + NW'(1);
      OP_POW_R: begin
        pa_q <= W'(1); pb_q <= a_q; pe_q <= (s_q + W'(1)) >> 1;
      end
      OP_POW_Y: begin
        r_q <= pa_q; pa_q <= W'(1); pb_q <= a_q; pe_q <= s_q;
      end
      OP_POW_B: begin
        y_q <= pa_q; pa_q <= W'(1); pb_q <= W'(n_q); pe_q <= s_q;
      end
      OP_J_INIT: begin
        b_q <= pa_q; j_q <= '0; k_q <= '0;
      end
      OP_POW_BJ2: begin
        pa_q <= W'(1); pb_q <= b_q; pe_q <= {j_q[W-2:0], 1'b0};
      end
      OP_POW_BJ: begin
        pa_q <= W'(1); pb_q <= b_q; pe_q <= j_q;
      end
      OP_MUL_BASE: pe_q <= pe_q >> 1;
      OP_MUL_TY:   sq_q <= alpha_q - AW'(2) - k_q;
      OP_MUL_TT:   sq_q <= sq_q - AW'(1);
      OP_J_UPD: begin
        if (t_q != W'(1)) begin
          j_q[k_q] <= 1'b1;
        end
        k_q <= k_q + AW'(1);
      end
      OP_MUL_ROOT: status_q <= ST_OK;
      OP_OUT: begin
        out_root_q   <= root_q;
        out_status_q <= status_q;
      end
      default: ;
    endcase
    if (mul_done) begin
      unique case (dest_q)
        OP_MUL_ACC:  pa_q   <= mres;
        OP_MUL_BASE: pb_q   <= mres;
        OP_JAC_REM:  ja_q   <= mres;
        OP_MUL_ROOT: root_q <= mres;
        default:     t_q    <= mres;
      endcase
    end
  end

  always_comb begin
    sts_o.a_ge_p   = (a_q >= p_q);
    sts_o.a_zero   = (a_q == '0);
    sts_o.p_bad    = !p_q[0] || (p_q < W'(3));
    sts_o.pe_zero  = (pe_q == '0);
    sts_o.pe_odd   = pe_q[0];
    sts_o.pa_one   = (pa_q == W'(1));
    sts_o.s_even   = !s_q[0];
    sts_o.ja_zero  = (ja_q == '0);
    sts_o.ja_even  = !ja_q[0];
    sts_o.jac_neg  = (jm_q == W'(1)) && neg_q;
    sts_o.n_ok     = !n_q[NW-1] && ({{(W-NW){1'b0}}, n_q} < p_q);
    sts_o.k_more   = ({1'b0, k_q} + (AW+1)'(2)) <= {1'b0, alpha_q};
    sts_o.sq_zero  = (sq_q == '0);
    sts_o.mul_done = mul_done;
    sts_o.out_free = !res_valid_q || out_ready_i;
  end

  assign out_valid_o  = res_valid_q;
  assign out_root_o   = out_root_q;
  assign out_status_o = out_status_q;

endmodule

[rtl/msr_ctrl.sv]
module msr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output msr_pkg::cmd_t cmd_o,
  input  msr_pkg::sts_t sts_i
);
  import msr_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_POW      = 5'd2;
  localparam logic [4:0] S_POW_SQ   = 5'd3;
  localparam logic [4:0] S_WAIT     = 5'd4;
  localparam logic [4:0] S_EULER    = 5'd5;
  localparam logic [4:0] S_SPLIT    = 5'd6;
  localparam logic [4:0] S_JAC_INIT = 5'd7;
  localparam logic [4:0] S_JAC      = 5'd8;
  localparam logic [4:0] S_JAC_REM  = 5'd9;
  localparam logic [4:0] S_N_CHK    = 5'd10;
  localparam logic [4:0] S_P_Y      = 5'd11;
  localparam logic [4:0] S_P_B      = 5'd12;
  localparam logic [4:0] S_J0       = 5'd13;
  localparam logic [4:0] S_K        = 5'd14;
  localparam logic [4:0] S_TY       = 5'd15;
  localparam logic [4:0] S_SQ       = 5'd16;
  localparam logic [4:0] S_ROOT     = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0] state_q, state_d, ret_q, ret_d, wret_q, wret_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    wret_d     = wret_q;
    in_ready_o = 1'b0;
    cmd_o.op         = OP_NONE;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.a_ge_p) begin
          cmd_o.op = OP_FINISH; cmd_o.res_status = ST_RANGE; state_d = S_DONE;
        end else if (sts_i.a_zero) begin
          cmd_o.op = OP_FINISH; cmd_o.res_status = ST_OK; state_d = S_DONE;
        end else if (sts_i.p_bad) begin
          cmd_o.op = OP_FINISH; cmd_o.res_status = ST_NONRES; state_d = S_DONE;
        end else begin
          cmd_o.op = OP_POW_EULER; ret_d = S_EULER; state_d = S_POW;
        end
      end
      // right-to-left square and multiply, pa = pb^pe
      S_POW: begin
        priority if (sts_i.pe_zero) begin
          state_d = ret_q;
        end else if (sts_i.pe_odd) begin
          cmd_o.op = OP_MUL_ACC; wret_d = S_POW_SQ; state_d = S_WAIT;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd_o.op = OP_MUL_BASE; wret_d = S_POW; state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = wret_q;
        end
      end
      S_EULER: begin
        if (sts_i.pa_one) begin
          state_d = S_SPLIT;
        end else begin
          cmd_o.op = OP_FINISH; cmd_o.res_status = ST_NONRES; state_d = S_DONE;
        end
      end
      S_SPLIT: begin
        if (sts_i.s_even) begin
          cmd_o.op = OP_SPLIT_STEP;
        end else begin
          cmd_o.op = OP_N_INIT; state_d = S_JAC_INIT;
        end
      end
      S_JAC_INIT: begin
        cmd_o.op = OP_JAC_INIT; state_d = S_JAC;
      end
      S_JAC: begin
        priority if (sts_i.ja_zero) begin
          if (sts_i.jac_neg) begin
            cmd_o.op = OP_POW_R; ret_d = S_P_Y; state_d = S_POW;
          end else begin
            cmd_o.op = OP_N_INC; state_d = S_N_CHK;
          end
        end else if (sts_i.ja_even) begin
          cmd_o.op = OP_JAC_HALF;
        end else begin
          cmd_o.op = OP_JAC_SWAP; state_d = S_JAC_REM;
        end
      end
      S_JAC_REM: begin
        cmd_o.op = OP_JAC_REM; wret_d = S_JAC; state_d = S_WAIT;
      end
      S_N_CHK: begin
        if (sts_i.n_ok) begin
          state_d = S_JAC_INIT;
        end else begin
          cmd_o.op = OP_FINISH; cmd_o.res_status = ST_NONRES; state_d = S_DONE;
        end
      end
      S_P_Y: begin
        cmd_o.op = OP_POW_Y; ret_d = S_P_B; state_d = S_POW;
      end
      S_P_B: begin
        cmd_o.op = OP_POW_B; ret_d = S_J0; state_d = S_POW;
      end
      S_J0: begin
        cmd_o.op = OP_J_INIT; state_d = S_K;
      end
      S_K: begin
        if (sts_i.k_more) begin
          cmd_o.op = OP_POW_BJ2; ret_d = S_TY;
        end else begin
          cmd_o.op = OP_POW_BJ; ret_d = S_ROOT;
        end
        state_d = S_POW;
      end
      S_TY: begin
        cmd_o.op = OP_MUL_TY; wret_d = S_SQ; state_d = S_WAIT;
      end
      S_SQ: begin
        if (sts_i.sq_zero) begin
          cmd_o.op = OP_J_UPD; state_d = S_K;
        end else begin
          cmd_o.op = OP_MUL_TT; wret_d = S_SQ; state_d = S_WAIT;
        end
      end
      S_ROOT: begin
        cmd_o.op = OP_MUL_ROOT; wret_d = S_DONE; state_d = S_WAIT;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      wret_q  <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      wret_q  <= wret_d;
    end
  end

endmodule
